@@ hdl/assert_macros.svh @@
// Assertion helpers; the bodies vanish when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define PTGV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptgv assertion failed");

`define PTGV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptgv assertion failed");

`else

`define PTGV_ASSERT_NOW(lbl, clk, rst_n, ante, cons)

`define PTGV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/ptgv_pkg.sv @@
package ptgv_pkg;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam int ANG_W = 26;  // angle in 2^-20 rad
    localparam int XY_W  = 34;  // cordic x/y datapath
    localparam int D_W   = 14;  // goal distance
    localparam int R_W   = 11;  // root term / speed

    localparam logic signed [ANG_W-1:0] ANG_PI      = 26'sd3294199;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 26'sd1647100;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 26'sd6588398;
    localparam logic [19:0]             GAIN_INV    = 20'd636751;

    localparam logic [D_W-1:0] NEAR_LIMIT   = 14'd100;
    localparam logic [R_W-1:0] SPEED_OFFSET = 11'd50;

    typedef enum logic [1:0] {
        MODE_OFFSET = 2'd0,
        MODE_PLAIN  = 2'd1,
        MODE_ROOT   = 2'd2,
        MODE_MAX    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        CFG_START_X = 3'd0,
        CFG_START_Y = 3'd1,
        CFG_GOAL_X  = 3'd2,
        CFG_GOAL_Y  = 3'd3,
        CFG_MODE    = 3'd4,
        CFG_MAX_SPD = 3'd5,
        CFG_CRUISE  = 3'd6,
        CFG_GAIN    = 3'd7
    } t_cfg_idx;

    localparam logic signed [12:0] RST_START_X = 13'sd550;
    localparam logic signed [12:0] RST_START_Y = 13'sd75;
    localparam logic signed [12:0] RST_GOAL_X  = 13'sd50;
    localparam logic signed [12:0] RST_GOAL_Y  = 13'sd375;
    localparam logic [9:0]         RST_MAX_SPD = 10'd400;
    localparam logic [9:0]         RST_CRUISE  = 10'd250;
    localparam logic [7:0]         RST_GAIN    = 8'd60;

    typedef struct packed {
        logic signed [D_W-1:0] ex;
        logic signed [D_W-1:0] ey;
        logic signed [14:0]    hd;
    } t_geo;

    typedef struct packed {
        logic far;
        t_geo geo;
    } t_near;

    typedef struct packed {
        logic                 zero;
        logic [R_W-1:0]       speed;
        logic signed [14:0]   hd;
    } t_aim;

    function automatic logic signed [ANG_W-1:0] atan_lut(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:       v = 26'sd823550;
            1:       v = 26'sd486170;
            2:       v = 26'sd256879;
            3:       v = 26'sd130396;
            4:       v = 26'sd65451;
            5:       v = 26'sd32757;
            6:       v = 26'sd16383;
            7:       v = 26'sd8192;
            8:       v = 26'sd4096;
            9:       v = 26'sd2048;
            10:      v = 26'sd1024;
            11:      v = 26'sd512;
            12:      v = 26'sd256;
            13:      v = 26'sd128;
            14:      v = 26'sd64;
            15:      v = 26'sd32;
            16:      v = 26'sd16;
            17:      v = 26'sd8;
            18:      v = 26'sd4;
            19:      v = 26'sd2;
            20:      v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

    // round to Q10.4 and clamp
    function automatic logic signed [14:0] sat_q104(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] q;
        logic signed [14:0]     r;
        q = (v + XY_W'(32768)) >>> 16;
        if (q > XY_W'(16383)) begin
            r = 15'sd16383;
        end else if (q < -XY_W'(16384)) begin
            r = -15'sd16384;
        end else begin
            r = q[14:0];
        end
        return r;
    endfunction

endpackage

@@ hdl/point_to_goal_velocity_core.sv @@
// Throughput: one request per cycle; the whole pipeline advances together and
// holds while a finished result waits on m_axis_tready.
// Reset (i_rst_n low, synchronous): pipeline emptied, configuration registers
// return to their defaults; configuration writes are taken whenever i_rst_n is high.
`include "assert_macros.svh"

module point_to_goal_velocity_core import ptgv_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // pos_x[12:0], pos_y[25:13], heading[40:26], zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // vel_fwd[14:0], vel_side[29:15], zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);
    // configuration
    logic signed [12:0] r_start_x, r_start_y, r_goal_x, r_goal_y;
    t_mode              r_mode;
    logic [9:0]         r_max_speed, r_cruise;
    logic [7:0]         r_gain;
    logic [27:0]        r_leg_sq;

    logic en;

    // stage registers
    logic                    r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld;
    logic                    r7_vld, r8_vld, r9_vld, r_out_vld;
    t_geo                    r1_geo, r2_geo, r3_geo, r4_geo, r5_geo;
    logic [27:0]             r2_esq, r3_dsq;
    logic [D_W-1:0]          r3_d;
    logic [21:0]             r3_gd, r4_gd;
    logic                    r4_far;
    logic                    r5_zero;
    logic [R_W-1:0]          r5_speed, r7_speed;
    logic signed [XY_W-1:0]  r6_x, r6_y;
    logic signed [ANG_W-1:0] r6_z, r7_ang, r8_ang, r9_z;
    t_aim                    r6_aim;
    logic [30:0]             r8_prod;
    logic signed [XY_W-1:0]  r9_x;
    logic signed [14:0]      r_out_fwd, r_out_side;

    // unit outputs
    logic                    d_vld, rt_vld, vc_vld, rc_vld;
    logic [D_W-1:0]          d_root;
    logic [R_W-1:0]          rt_root;
    t_geo                    d_geo;
    t_near                   rt_near, n4_near;
    t_aim                    vc_aim;
    logic signed [XY_W-1:0]  vc_x, vc_y, rc_x, rc_y;
    logic signed [ANG_W-1:0] vc_z, rc_z;
    logic                    rc_side;

    logic signed [12:0] in_pos_x, in_pos_y;
    logic signed [14:0] in_hd;
    logic signed [D_W-1:0] lx, ly;

    assign in_pos_x = s_axis_tdata[12:0];
    assign in_pos_y = s_axis_tdata[25:13];
    assign in_hd    = s_axis_tdata[40:26];

    assign en            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x   <= RST_START_X;
            r_start_y   <= RST_START_Y;
            r_goal_x    <= RST_GOAL_X;
            r_goal_y    <= RST_GOAL_Y;
            r_mode      <= MODE_OFFSET;
            r_max_speed <= RST_MAX_SPD;
            r_cruise    <= RST_CRUISE;
            r_gain      <= RST_GAIN;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_START_X: r_start_x   <= i_cfg_data;
                CFG_START_Y: r_start_y   <= i_cfg_data;
                CFG_GOAL_X:  r_goal_x    <= i_cfg_data;
                CFG_GOAL_Y:  r_goal_y    <= i_cfg_data;
                CFG_MODE:    r_mode      <= t_mode'(i_cfg_data[1:0]);
                CFG_MAX_SPD: r_max_speed <= i_cfg_data[9:0];
                CFG_CRUISE:  r_cruise    <= i_cfg_data[9:0];
                CFG_GAIN:    r_gain      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // leg length squared, follows the config registers
    assign lx = D_W'(r_goal_x) - D_W'(r_start_x);
    assign ly = D_W'(r_goal_y) - D_W'(r_start_y);

    always_ff @(posedge i_clk) begin
        r_leg_sq <= 28'(lx * lx) + 28'(ly * ly);
    end

    // valid chain of the local stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r7_vld    <= 1'b0;
            r8_vld    <= 1'b0;
            r9_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r1_vld    <= s_axis_tvalid;
            r2_vld    <= r1_vld;
            r3_vld    <= d_vld;
            r4_vld    <= r3_vld;
            r5_vld    <= rt_vld;
            r6_vld    <= r5_vld;
            r7_vld    <= vc_vld;
            r8_vld    <= r7_vld;
            r9_vld    <= r8_vld;
            r_out_vld <= rc_vld;
        end
    end

    // offsets to goal, then squared distance
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_geo.ex <= D_W'(r_goal_x) - D_W'(in_pos_x);
            r1_geo.ey <= D_W'(r_goal_y) - D_W'(in_pos_y);
            r1_geo.hd <= in_hd;
            r2_esq    <= 28'(r1_geo.ex * r1_geo.ex) + 28'(r1_geo.ey * r1_geo.ey);
            r2_geo    <= r1_geo;
        end
    end

    ptgv_isqrt #(.OW(D_W), .SW($bits(t_geo))) u_dist_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r2_vld),
        .i_n    (r2_esq),
        .i_side (r2_geo),
        .o_vld  (d_vld),
        .o_root (d_root),
        .o_side (d_geo)
    );

    // 2d > L is the same test as 4d^2 > L^2; far is also set when d > NEAR_LIMIT
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_d   <= d_root;
            r3_dsq <= 28'(d_root * d_root);
            r3_gd  <= 22'(r_gain * d_root);
            r3_geo <= d_geo;
            r4_far <= ({r3_dsq, 2'b00} > {2'b00, r_leg_sq}) || (r3_d > NEAR_LIMIT);
            r4_gd  <= r3_gd;
            r4_geo <= r3_geo;
        end
    end

    assign n4_near.far = r4_far;
    assign n4_near.geo = r4_geo;

    ptgv_isqrt #(.OW(R_W), .SW($bits(t_near))) u_root_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r4_vld),
        .i_n    (r4_gd),
        .i_side (n4_near),
        .o_vld  (rt_vld),
        .o_root (rt_root),
        .o_side (rt_near)
    );

    // speed profile
    logic [R_W-1:0] n5_speed;
    always_comb begin
        case (r_mode)
            MODE_MAX:  n5_speed = R_W'(r_max_speed);
            MODE_ROOT: n5_speed = rt_root;
            default: begin
                if (rt_near.far) begin
                    n5_speed = R_W'(r_cruise);
                end else if (r_mode == MODE_OFFSET) begin
                    n5_speed = rt_root + SPEED_OFFSET;
                end else begin
                    n5_speed = rt_root;
                end
            end
        endcase
    end

    // pre-rotation by pi for the left half plane
    logic signed [XY_W-1:0] n6_x;
    always_comb begin
        n6_x = $signed({{(XY_W - D_W - 16){r5_geo.ex[D_W-1]}}, r5_geo.ex, 16'b0});
    end

    logic signed [XY_W-1:0] n6_y;
    always_comb begin
        n6_y = $signed({{(XY_W - D_W - 16){r5_geo.ey[D_W-1]}}, r5_geo.ey, 16'b0});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_speed    <= n5_speed;
            r5_geo      <= rt_near.geo;
            r5_zero     <= (rt_near.geo.ex == '0) && (rt_near.geo.ey == '0);
            r6_aim.zero  <= r5_zero;
            r6_aim.speed <= r5_speed;
            r6_aim.hd    <= r5_geo.hd;
            if (r5_geo.ex < 0) begin
                r6_x <= -n6_x;
                r6_y <= -n6_y;
                r6_z <= (r5_geo.ey >= 0) ? ANG_PI : -ANG_PI;
            end else begin
                r6_x <= n6_x;
                r6_y <= n6_y;
                r6_z <= '0;
            end
        end
    end

    ptgv_cordic #(.STEPS(CORDIC_STEPS), .VECT(1'b1), .SW($bits(t_aim))) u_bearing (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r6_vld),
        .i_x    (r6_x),
        .i_y    (r6_y),
        .i_z    (r6_z),
        .i_side (r6_aim),
        .o_vld  (vc_vld),
        .o_x    (vc_x),
        .o_y    (vc_y),
        .o_z    (vc_z),
        .o_side (vc_aim)
    );

    // steering angle: subtract heading, wrap, fold into the right half plane
    logic signed [ANG_W-1:0] n7_bear;
    logic signed [ANG_W-1:0] n7_hd;
    assign n7_bear = vc_aim.zero ? '0 : vc_z;
    assign n7_hd   = $signed({{(ANG_W - 23){vc_aim.hd[14]}}, vc_aim.hd, 8'b0});

    logic signed [ANG_W-1:0] n8_ang;
    always_comb begin
        if (r7_ang > ANG_PI) begin
            n8_ang = r7_ang - ANG_TWO_PI;
        end else if (r7_ang < -ANG_PI) begin
            n8_ang = r7_ang + ANG_TWO_PI;
        end else begin
            n8_ang = r7_ang;
        end
    end

    logic signed [XY_W-1:0] n9_mag;
    assign n9_mag = $signed({{(XY_W - 31){1'b0}}, r8_prod});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_ang   <= n7_bear - n7_hd;
            r7_speed <= vc_aim.speed;
            r8_ang   <= n8_ang;
            r8_prod  <= 31'(r7_speed * GAIN_INV);
            if (r8_ang > ANG_HALF_PI) begin
                r9_z <= r8_ang - ANG_PI;
                r9_x <= -n9_mag;
            end else if (r8_ang < -ANG_HALF_PI) begin
                r9_z <= r8_ang + ANG_PI;
                r9_x <= -n9_mag;
            end else begin
                r9_z <= r8_ang;
                r9_x <= n9_mag;
            end
        end
    end

    ptgv_cordic #(.STEPS(CORDIC_STEPS), .VECT(1'b0), .SW(1)) u_rotate (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r9_vld),
        .i_x    (r9_x),
        .i_y    ('0),
        .i_z    (r9_z),
        .i_side (1'b0),
        .o_vld  (rc_vld),
        .o_x    (rc_x),
        .o_y    (rc_y),
        .o_z    (rc_z),
        .o_side (rc_side)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_fwd  <= sat_q104(rc_x);
            r_out_side <= sat_q104(rc_y);
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_out_side, r_out_fwd};

    `PTGV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_vld && !m_axis_tready, r_out_vld && $stable(r_out_fwd))
    `PTGV_ASSERT_NOW(a_max_speed, i_clk, i_rst_n, r5_vld && (r_mode == MODE_MAX), r5_speed == R_W'(r_max_speed))
    `PTGV_ASSERT_NOW(a_fold_range, i_clk, i_rst_n, r9_vld, (r9_z <= ANG_HALF_PI) && (r9_z >= -ANG_HALF_PI))

endmodule

@@ hdl/ptgv_isqrt.sv @@
module ptgv_isqrt import ptgv_pkg::*; #(
    parameter int OW = D_W,
    parameter int SW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [2*OW-1:0]   i_n,
    input  logic [SW-1:0]     i_side,
    output logic              o_vld,
    output logic [OW-1:0]     o_root,
    output logic [SW-1:0]     o_side
);
    localparam int IW = 2 * OW;
    localparam int RW = OW + 2;

    logic              r_vld  [OW];
    logic [RW-1:0]     r_rem  [OW];
    logic [OW-1:0]     r_root [OW];
    logic [IW-1:0]     r_n    [OW];
    logic [SW-1:0]     r_side [OW];

    // one result bit per stage, restoring
    for (genvar s = 0; s < OW; s++) begin : g_stage
        logic              p_vld;
        logic [RW-1:0]     p_rem;
        logic [OW-1:0]     p_root;
        logic [IW-1:0]     p_n;
        logic [SW-1:0]     p_side;
        logic [RW+1:0]     rem_sh;
        logic [RW+1:0]     trial;
        logic [RW-1:0]     n_rem;
        logic [OW-1:0]     n_root;

        if (s == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_n    = i_n;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[s-1];
            assign p_rem  = r_rem[s-1];
            assign p_root = r_root[s-1];
            assign p_n    = r_n[s-1];
            assign p_side = r_side[s-1];
        end

        always_comb begin
            rem_sh = {p_rem, p_n[IW-1-2*s -: 2]};
            trial  = {2'b00, p_root, 2'b01};
            if (rem_sh >= trial) begin
                n_rem  = RW'(rem_sh - trial);
                n_root = {p_root[OW-2:0], 1'b1};
            end else begin
                n_rem  = RW'(rem_sh);
                n_root = {p_root[OW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_root[s] <= n_root;
                r_n[s]    <= p_n;
                r_side[s] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[OW-1];
    assign o_root = r_root[OW-1];
    assign o_side = r_side[OW-1];

endmodule

@@ hdl/ptgv_cordic.sv @@
module ptgv_cordic import ptgv_pkg::*; #(
    parameter int   STEPS = CORDIC_STEPS_DEF,
    parameter bit   VECT  = 1'b0,
    parameter int   SW    = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  logic signed [XY_W-1:0]  i_x,
    input  logic signed [XY_W-1:0]  i_y,
    input  logic signed [ANG_W-1:0] i_z,
    input  logic [SW-1:0]           i_side,
    output logic                    o_vld,
    output logic signed [XY_W-1:0]  o_x,
    output logic signed [XY_W-1:0]  o_y,
    output logic signed [ANG_W-1:0] o_z,
    output logic [SW-1:0]           o_side
);
    logic                    r_vld  [STEPS];
    logic signed [XY_W-1:0]  r_x    [STEPS];
    logic signed [XY_W-1:0]  r_y    [STEPS];
    logic signed [ANG_W-1:0] r_z    [STEPS];
    logic [SW-1:0]           r_side [STEPS];

    for (genvar s = 0; s < STEPS; s++) begin : g_stage
        logic                    p_vld;
        logic signed [XY_W-1:0]  p_x;
        logic signed [XY_W-1:0]  p_y;
        logic signed [ANG_W-1:0] p_z;
        logic [SW-1:0]           p_side;
        logic signed [XY_W-1:0]  sx;
        logic signed [XY_W-1:0]  sy;
        logic                    turn_neg;
        logic signed [XY_W-1:0]  n_x;
        logic signed [XY_W-1:0]  n_y;
        logic signed [ANG_W-1:0] n_z;

        if (s == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_x    = i_x;
            assign p_y    = i_y;
            assign p_z    = i_z;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[s-1];
            assign p_x    = r_x[s-1];
            assign p_y    = r_y[s-1];
            assign p_z    = r_z[s-1];
            assign p_side = r_side[s-1];
        end

        // vectoring drives y to zero, rotation drives z to zero
        always_comb begin
            sx       = p_x >>> s;
            sy       = p_y >>> s;
            turn_neg = VECT ? (p_y > 0) : (p_z < 0);
            if (turn_neg) begin
                n_x = p_x + sy;
                n_y = p_y - sx;
                n_z = p_z + atan_lut(s);
            end else begin
                n_x = p_x - sy;
                n_y = p_y + sx;
                n_z = p_z - atan_lut(s);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[s]    <= n_x;
                r_y[s]    <= n_y;
                r_z[s]    <= n_z;
                r_side[s] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[STEPS-1];
    assign o_x    = r_x[STEPS-1];
    assign o_y    = r_y[STEPS-1];
    assign o_z    = r_z[STEPS-1];
    assign o_side = r_side[STEPS-1];

endmodule
